// File: src/ffca_pkg.sv
// Shared codes and types of the first-fit credit admission queue.
package ffca_pkg;

    localparam int OP_W  = 2;
    localparam int AMT_W = 32;
    localparam int ST_W  = 3;

    typedef logic [OP_W-1:0]  op_t;
    typedef logic [AMT_W-1:0] amt_t;
    typedef logic [ST_W-1:0]  status_t;

    localparam op_t OP_PUSH = 2'd0;
    localparam op_t OP_POP  = 2'd1;
    localparam op_t OP_DONE = 2'd2;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_EMPTY     = 3'd1;
    localparam status_t ST_WAIT      = 3'd2;
    localparam status_t ST_TOO_LARGE = 3'd3;
    localparam status_t ST_FULL      = 3'd4;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PUSH = 2'd0;
    localparam kind_t KIND_POP  = 2'd1;
    localparam kind_t KIND_DONE = 2'd2;
    localparam kind_t KIND_NOP  = 2'd3;

    typedef struct packed {
        kind_t kind;
        amt_t  amount;
    } cmd_t;

endpackage

// File: src/ffca_if.sv
// Channel interfaces of the first-fit credit admission queue.
interface ffca_item_if #(
    parameter int ID_BITS = 16
);
    logic                valid;
    logic                ready;
    ffca_pkg::op_t       op;
    logic [ID_BITS-1:0]  job_id;
    ffca_pkg::amt_t      amount;

    modport source (output valid, output op, output job_id, output amount, input ready);
    modport sink   (input valid, input op, input job_id, input amount, output ready);
endinterface

interface ffca_result_if #(
    parameter int ID_BITS = 16
);
    logic                valid;
    logic                ready;
    ffca_pkg::status_t   status;
    logic [ID_BITS-1:0]  grant_id;
    ffca_pkg::amt_t      grant_amount;
    ffca_pkg::amt_t      budget_left;

    modport source (output valid, output status, output grant_id, output grant_amount,
                    output budget_left, input ready);
    modport sink   (input valid, input status, input grant_id, input grant_amount,
                    input budget_left, output ready);
endinterface

interface ffca_cfg_if;
    logic           valid;
    logic           ready;
    ffca_pkg::amt_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/ffca_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/ffca_front.sv
// Front end: accepts items, decodes the operation and queues commands.
module ffca_front #(
    parameter int ID_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    ffca_item_if.sink          item,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output ffca_pkg::cmd_t     cmd,
    output logic [ID_BITS-1:0] cmd_id
);

    ffca_pkg::cmd_t     q_cmd_reg [2];
    logic [ID_BITS-1:0] q_id_reg  [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         fill_reg;
    logic [1:0]         fill_next;
    logic               push_en;
    logic               pop_en;
    ffca_pkg::kind_t    kind;

    always_comb
    begin
        unique case (item.op)
            ffca_pkg::OP_PUSH: kind = ffca_pkg::KIND_PUSH;
            ffca_pkg::OP_POP:  kind = ffca_pkg::KIND_POP;
            ffca_pkg::OP_DONE: kind = ffca_pkg::KIND_DONE;
            default:           kind = ffca_pkg::KIND_NOP;
        endcase
    end

    assign item.ready = (fill_reg != 2'd2);
    assign push_en    = item.valid && item.ready;
    assign cmd_valid  = (fill_reg != 2'd0);
    assign pop_en     = cmd_valid && cmd_ready;
    assign cmd        = q_cmd_reg[rd_ptr_reg];
    assign cmd_id     = q_id_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push_en && !pop_en)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop_en && !push_en)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            q_cmd_reg[wr_ptr_reg] <= '{kind: kind, amount: item.amount};
            q_id_reg[wr_ptr_reg]  <= item.job_id;
        end
    end

endmodule

// File: src/ffca_back.sv
// Back end: budget, job table sequencer and result register.
module ffca_back #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  ffca_pkg::cmd_t     cmd,
    input  logic [ID_BITS-1:0] cmd_id,
    ffca_cfg_if.sink           cfg,
    ffca_result_if.source      result
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENT_W = ID_BITS + ffca_pkg::AMT_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    ffca_pkg::amt_t     budget_reg, budget_next;
    logic [ID_BITS-1:0] gid_reg, gid_next;
    ffca_pkg::amt_t     gamt_reg, gamt_next;

    logic               out_valid_reg;
    ffca_pkg::status_t  out_status_reg;
    logic [ID_BITS-1:0] out_gid_reg;
    ffca_pkg::amt_t     out_gamt_reg;
    ffca_pkg::amt_t     out_budget_reg;

    logic               res_load;
    ffca_pkg::status_t  res_status;
    logic [ID_BITS-1:0] res_gid;
    ffca_pkg::amt_t     res_gamt;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [ENT_W-1:0]   ram_wdata, ram_rdata;
    logic [ID_BITS-1:0] rd_id;
    ffca_pkg::amt_t     rd_need;

    logic [CNT_W-1:0]   pos_inc;
    logic [CNT_W-1:0]   pos_dec;
    logic               more;
    logic               cmd_take;
    logic [ffca_pkg::AMT_W:0] sum;

    ffca_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_id   = ram_rdata[ENT_W-1 -: ID_BITS];
    assign rd_need = ram_rdata[ffca_pkg::AMT_W-1:0];

    assign cmd_ready = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign cmd_take  = cmd_valid && cmd_ready;
    assign cfg.ready = 1'b1;

    assign pos_inc = pos_reg + ONE_C;
    assign pos_dec = pos_reg - ONE_C;
    assign more    = (pos_inc < count_reg);
    assign sum     = {1'b0, budget_reg} + {1'b0, cmd.amount};

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        budget_next = budget_reg;
        gid_next    = gid_reg;
        gamt_next   = gamt_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_dec[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = pos_inc[AW-1:0];
        res_load    = 1'b0;
        res_status  = ffca_pkg::ST_OK;
        res_gid     = '0;
        res_gamt    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    case (cmd.kind)
                        ffca_pkg::KIND_PUSH:
                        begin
                            res_load = 1'b1;
                            if (cmd.amount > budget_reg)
                            begin
                                res_status = ffca_pkg::ST_TOO_LARGE;
                            end
                            else if (count_reg == DEPTH_C)
                            begin
                                res_status = ffca_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = {cmd_id, cmd.amount};
                                count_next = count_reg + ONE_C;
                            end
                        end
                        ffca_pkg::KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load   = 1'b1;
                                res_status = ffca_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                pos_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        ffca_pkg::KIND_DONE:
                        begin
                            res_load    = 1'b1;
                            budget_next = sum[ffca_pkg::AMT_W] ? '1 : sum[ffca_pkg::AMT_W-1:0];
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_need <= budget_reg)
                begin
                    gid_next    = rd_id;
                    gamt_next   = rd_need;
                    budget_next = budget_reg - rd_need;
                    if (more)
                    begin
                        // Entries behind the hit move down one place each cycle.
                        ram_re     = 1'b1;
                        pos_next   = pos_inc;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - ONE_C;
                        res_load   = 1'b1;
                        res_gid    = rd_id;
                        res_gamt   = rd_need;
                        state_next = S_IDLE;
                    end
                end
                else if (more)
                begin
                    ram_re   = 1'b1;
                    pos_next = pos_inc;
                end
                else
                begin
                    res_load   = 1'b1;
                    res_status = ffca_pkg::ST_WAIT;
                    state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                ram_we = 1'b1;
                if (more)
                begin
                    ram_re   = 1'b1;
                    pos_next = pos_inc;
                end
                else
                begin
                    count_next = count_reg - ONE_C;
                    res_load   = 1'b1;
                    res_gid    = gid_reg;
                    res_gamt   = gamt_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Reloads budget; user lets a limit write arrive only while block is idle; unchecked.
        if (cfg.valid)
        begin
            budget_next = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            count_reg     <= '0;
            budget_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            budget_reg <= budget_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gid_reg  <= gid_next;
        gamt_reg <= gamt_next;
        if (res_load)
        begin
            out_status_reg <= res_status;
            out_gid_reg    <= res_gid;
            out_gamt_reg   <= res_gamt;
            out_budget_reg <= budget_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.grant_id     = out_gid_reg;
    assign result.grant_amount = out_gamt_reg;
    assign result.budget_left  = out_budget_reg;

endmodule

// File: src/first_fit_credit_admission_queue.sv
// Top level of the first-fit credit admission queue.
//
// Jobs arrive on the item channel as push, pop or completion operations and
// each operation returns exactly one transfer on the result channel, in order.
// The cfg channel writes the resource limit and reloads the remaining budget;
// it is always ready. The user must write it only while no operation is in
// flight; the block does not enforce this. A two-entry command queue sits
// between the decoding front end and the back end, so items are still taken
// while a result waits for the receiver. Push, completion and unused codes
// give their result in the cycle after the back end takes them. A pop walks
// the job table memory one entry a cycle from the oldest job, then on a fit
// moves each later entry down one place a cycle, using the single read port
// of the table memory. The back end takes no command until a pop is done.
// Reset empties the table and clears the budget to zero; no clearing pass is
// needed. When the receiver stalls, the result register holds its transfer,
// the back end stops taking commands and the item channel drops ready once
// the command queue is full.
module first_fit_credit_admission_queue #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    ffca_item_if.sink     item,
    ffca_result_if.source result,
    ffca_cfg_if.sink      cfg
);

    logic               cmd_valid;
    logic               cmd_ready;
    ffca_pkg::cmd_t     cmd;
    logic [ID_BITS-1:0] cmd_id;

    ffca_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cmd_id    (cmd_id)
    );

    ffca_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cmd_id    (cmd_id),
        .cfg       (cfg),
        .result    (result)
    );

endmodule
